>>> rtl/cmtr_pkg.sv
// shared types and constants of the constant multiplier term recoder
// no dependencies
package cmtr_pkg;

    localparam int WIDTH     = 32;
    localparam int KW        = $clog2(WIDTH);
    localparam int MAX_TERMS = 18;
    localparam int CW        = $clog2(MAX_TERMS);

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [KW-1:0]    shift_t;
    typedef logic [CW-1:0]    count_t;

endpackage

>>> rtl/constant_multiplier_term_recoder_unit.sv
// top level of the constant multiplier term recoder: sequencer, shared adder and leading one detector
// depends on cmtr_pkg, cmtr_alu, cmtr_lod
//
// Takes a signed constant word and returns, largest first, the signed shift terms
// +-(x << k) whose sum equals constant * x modulo 2^32, one result word per term,
// with last_term marking the final one; a zero constant gives a single word with
// is_zero_product set. The block handles one constant at a time and s_ready is low
// from acceptance until the last term is taken. Each term goes through magnitude
// (through the shared adder), leading one detect, rounding decision and output,
// plus the wait for m_ready; the remainder update goes through the same adder. A
// constant gives at most 18 terms.
module constant_multiplier_term_recoder_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_constant_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_shift_amount,
    output logic               m_negate_term,
    output logic               m_is_zero_product,
    output logic               m_last_term
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAG  = 5'b00010,
        S_LOD  = 5'b00100,
        S_DEC  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    cmtr_pkg::count_t count_reg, count_next;

    cmtr_pkg::word_t  v_reg, v_next;
    cmtr_pkg::word_t  mag_reg, mag_next;
    logic             neg_reg, neg_next;
    cmtr_pkg::shift_t f_reg, f_next;
    cmtr_pkg::shift_t k_reg, k_next;
    logic             zero_reg, zero_next;
    logic             last_reg, last_next;

    cmtr_pkg::word_t  alu_a, alu_b, alu_y;
    logic             alu_sub;
    cmtr_pkg::shift_t lod_pos;

    cmtr_pkg::word_t  one_hot, rest, half;
    logic             pow2, round_up;

    cmtr_alu u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .sub    (alu_sub),
        .result (alu_y)
    );

    cmtr_lod u_lod (
        .mag (mag_reg),
        .pos (lod_pos)
    );

    // rounding decision on the registered magnitude and leading one
    always_comb begin
        one_hot  = cmtr_pkg::word_t'(1) << f_reg;
        rest     = mag_reg & ~one_hot;
        half     = one_hot >> 1;
        pow2     = (rest == '0);
        round_up = (rest > half) && (f_reg < cmtr_pkg::shift_t'(cmtr_pkg::WIDTH - 1));
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        v_next     = v_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        f_next     = f_reg;
        k_next     = k_reg;
        zero_next  = zero_reg;
        last_next  = last_reg;
        alu_a      = '0;
        alu_b      = v_reg;
        alu_sub    = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    v_next     = cmtr_pkg::word_t'(s_constant_value);
                    count_next = '0;
                    state_next = S_MAG;
                end
            end
            S_MAG: begin
                neg_next = v_reg[cmtr_pkg::WIDTH-1];
                mag_next = v_reg[cmtr_pkg::WIDTH-1] ? alu_y : v_reg;
                if (v_reg == '0) begin
                    k_next     = '0;
                    neg_next   = 1'b0;
                    zero_next  = 1'b1;
                    last_next  = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    zero_next  = 1'b0;
                    state_next = S_LOD;
                end
            end
            S_LOD: begin
                f_next     = lod_pos;
                state_next = S_DEC;
            end
            S_DEC: begin
                k_next     = f_reg + cmtr_pkg::shift_t'(round_up && !pow2);
                last_next  = pow2 || (count_reg == cmtr_pkg::count_t'(cmtr_pkg::MAX_TERMS - 1));
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // remainder: v + p for a negative value, v - p otherwise
                alu_a   = v_reg;
                alu_b   = cmtr_pkg::word_t'(1) << k_reg;
                alu_sub = !neg_reg;
                if (m_ready) begin
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        v_next     = alu_y;
                        count_next = count_reg + cmtr_pkg::count_t'(1);
                        state_next = S_MAG;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        f_reg    <= f_next;
        k_reg    <= k_next;
        zero_reg <= zero_next;
        last_reg <= last_next;
    end

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = (state_reg == S_EMIT);
    assign m_shift_amount    = 5'(k_reg);
    assign m_negate_term     = neg_reg;
    assign m_is_zero_product = zero_reg;
    assign m_last_term       = last_reg;

endmodule

>>> rtl/cmtr_alu.sv
// shared add/subtract unit of the term recoder, used for negation and remainder update
// depends on cmtr_pkg
module cmtr_alu (
    input  cmtr_pkg::word_t op_a,
    input  cmtr_pkg::word_t op_b,
    input  logic            sub,
    output cmtr_pkg::word_t result
);

    always_comb begin
        if (sub) begin
            result = op_a - op_b;
        end else begin
            result = op_a + op_b;
        end
    end

endmodule

>>> rtl/cmtr_lod.sv
// leading one detector of the term recoder: floor log2 of a magnitude word
// depends on cmtr_pkg
module cmtr_lod (
    input  cmtr_pkg::word_t  mag,
    output cmtr_pkg::shift_t pos
);

    always_comb begin
        pos = '0;
        for (int i = 0; i < cmtr_pkg::WIDTH; i++) begin
            if (mag[i]) begin
                pos = cmtr_pkg::shift_t'(i);
            end
        end
    end

endmodule

>>> rtl/cmtr_checker.sv
// port-level checks of the constant multiplier term recoder and their bind
// depends on constant_multiplier_term_recoder_unit
module cmtr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [4:0]         m_shift_amount,
    input logic               m_negate_term,
    input logic               m_is_zero_product,
    input logic               m_last_term
);

    // one constant at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before the decomposition finished");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a term word is pending");

    a_more_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_term |=> !s_ready)
        else $error("input ready before the last term word");

    a_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_zero_product |->
            m_last_term && !m_negate_term && (m_shift_amount == 5'd0))
        else $error("zero product word malformed");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shift_amount)
            && $stable(m_negate_term) && $stable(m_is_zero_product) && $stable(m_last_term))
        else $error("stalled term word changed");

endmodule

bind constant_multiplier_term_recoder_unit cmtr_checker u_cmtr_checker (.*);
